/* rtl/core/cma_pkg.sv */
`default_nettype none

package cma_pkg;

    // defaults for the top-level parameters
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    // fixed field widths
    localparam int LANES       = 8;                 // ch0..ch7 in every sample transfer
    localparam int FIELD_W     = 16;
    localparam int CH_W        = 3;                 // row / col index
    localparam int CFG_W       = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
    localparam int SUM_W       = 64;
    localparam int COUNT_W     = 32;
    localparam int VALUE_W     = 33;
    localparam int IN_TDATA_W  = LANES * FIELD_W;
    localparam int OUT_BITS    = 2 * CH_W + VALUE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // microcode
    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] S_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] S_MAC      = 4'd2;
    localparam logic [PC_W-1:0] S_DRAIN    = 4'd3;
    localparam logic [PC_W-1:0] S_EMIT_RD  = 4'd4;
    localparam logic [PC_W-1:0] S_DIV_GO   = 4'd5;
    localparam logic [PC_W-1:0] S_DIV_WAIT = 4'd6;
    localparam logic [PC_W-1:0] S_OUT      = 4'd7;
    localparam logic [PC_W-1:0] S_NEXT     = 4'd8;
    localparam logic [PC_W-1:0] S_CLEAR    = 4'd9;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_FINISH,
        C_NOT_LAST,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic ready;     // take a sample transfer
        logic rc_clr;    // row / col back to zero
        logic mac;       // issue one multiply-accumulate
        logic cnt_inc;   // bump sample count
        logic mem_rd;    // read one accumulator for emit
        logic div_go;    // start divider
        logic out_load;  // load output register
        logic rc_adv;    // step to next pair
        logic acc_clr;   // drop all sums and the count
    } t_ctrl;

    typedef struct packed {
        t_ctrl            ctrl;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic finish;
        logic not_last;
        logic div_busy;
        logic out_busy;
    } t_stat;

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        w.cond = C_NEVER;
        case (pc)
            S_WAIT: begin
                w.ctrl.ready  = 1'b1;
                w.ctrl.rc_clr = 1'b1;
                w.cond        = C_NO_ACCEPT;
                w.target      = S_WAIT;
            end
            S_DISPATCH: begin
                w.cond   = C_FINISH;
                w.target = S_EMIT_RD;
            end
            S_MAC: begin
                w.ctrl.mac    = 1'b1;
                w.ctrl.rc_adv = 1'b1;
                w.cond        = C_NOT_LAST;
                w.target      = S_MAC;
            end
            S_DRAIN: begin
                w.ctrl.cnt_inc = 1'b1;
                w.cond         = C_ALWAYS;
                w.target       = S_WAIT;
            end
            S_EMIT_RD: begin
                w.ctrl.mem_rd = 1'b1;
            end
            S_DIV_GO: begin
                w.ctrl.div_go = 1'b1;
            end
            S_DIV_WAIT: begin
                w.cond   = C_DIV_BUSY;
                w.target = S_DIV_WAIT;
            end
            S_OUT: begin
                w.ctrl.out_load = 1'b1;
                w.cond          = C_OUT_BUSY;
                w.target        = S_OUT;
            end
            S_NEXT: begin
                w.ctrl.rc_adv = 1'b1;
                w.cond        = C_NOT_LAST;
                w.target      = S_EMIT_RD;
            end
            S_CLEAR: begin
                w.ctrl.acc_clr = 1'b1;
                w.cond         = C_ALWAYS;
                w.target       = S_WAIT;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cma_seq.sv */
`default_nettype none

module cma_seq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire cma_pkg::t_stat i_stat,
    output cma_pkg::t_ctrl    o_ctrl
);

    logic [cma_pkg::PC_W-1:0] r_pc;
    logic [cma_pkg::PC_W-1:0] n_pc;
    cma_pkg::t_uword          uw;
    logic                     take;

    assign uw     = cma_pkg::ucode(r_pc);
    assign o_ctrl = uw.ctrl;

    always_comb begin
        case (uw.cond)
            cma_pkg::C_NEVER:     take = 1'b0;
            cma_pkg::C_ALWAYS:    take = 1'b1;
            cma_pkg::C_NO_ACCEPT: take = !i_stat.accept;
            cma_pkg::C_FINISH:    take = i_stat.finish;
            cma_pkg::C_NOT_LAST:  take = i_stat.not_last;
            cma_pkg::C_DIV_BUSY:  take = i_stat.div_busy;
            cma_pkg::C_OUT_BUSY:  take = i_stat.out_busy;
            default:              take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cma_pkg::S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cma_div.sv */
`default_nettype none

module cma_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [cma_pkg::SUM_W-1:0]    i_dividend,
    input  wire  [cma_pkg::COUNT_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [cma_pkg::SUM_W-1:0]    o_quotient
);

    localparam int ITER_W = $clog2(cma_pkg::SUM_W);
    localparam int DW     = cma_pkg::COUNT_W;

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic [cma_pkg::SUM_W-1:0] r_quo;

    logic [DW+1:0]     diff;
    logic              q_bit;

    // restoring division, one quotient bit per cycle
    always_comb begin
        diff  = {1'b0, r_rem, r_quo[cma_pkg::SUM_W-1]} - {2'b00, r_div};
        q_bit = !diff[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= (i_divisor != '0);
        end else if (r_busy && r_iter == ITER_W'(cma_pkg::SUM_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_iter <= '0;
        end else if (r_busy) begin
            r_quo  <= {r_quo[cma_pkg::SUM_W-2:0], q_bit};
            r_rem  <= q_bit ? diff[DW-1:0] : {r_rem[DW-2:0], r_quo[cma_pkg::SUM_W-1]};
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/core/cma_dp.sv */
`default_nettype none

module cma_dp #(
    parameter int MAX_CHANNELS = cma_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire cma_pkg::t_ctrl               i_ctrl,
    input  wire                               i_accept,
    input  wire  [cma_pkg::IN_TDATA_W-1:0]    i_samples,
    input  wire                               i_func,
    input  wire  [cma_pkg::CFG_W-1:0]         i_chan,
    input  wire                               i_out_ready,
    input  wire                               i_div_busy,
    input  wire  [cma_pkg::SUM_W-1:0]         i_quotient,
    output logic                              o_div_start,
    output logic [cma_pkg::SUM_W-1:0]         o_dividend,
    output logic [cma_pkg::COUNT_W-1:0]       o_divisor,
    output cma_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output logic [cma_pkg::CH_W-1:0]          o_row,
    output logic [cma_pkg::CH_W-1:0]          o_col,
    output logic [cma_pkg::VALUE_W-1:0]       o_value,
    output logic                              o_last
);

    localparam int DEPTH    = MAX_CHANNELS * MAX_CHANNELS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CI_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int SW       = cma_pkg::SUM_W;
    localparam int CW       = cma_pkg::CH_W;
    localparam int VW       = cma_pkg::VALUE_W;
    localparam logic [SW-1:0] LIMIT = SW'(64'd1 << (VW - 2));

    logic signed [SAMPLE_BITS-1:0] r_x [MAX_CHANNELS];
    logic                          r_func;
    logic [CW-1:0]                 r_row;
    logic [CW-1:0]                 r_col;

    logic [SW-1:0]                 mem [DEPTH];
    logic [DEPTH-1:0]              r_vld;
    logic [SW-1:0]                 r_rd_data;
    logic                          r_rd_vld;
    logic                          r_wr_en;
    logic [ADDR_W-1:0]             r_wr_addr;
    logic signed [PROD_W-1:0]      r_prod;

    logic [cma_pkg::COUNT_W-1:0]   r_count;
    logic                          r_neg;
    logic                          r_out_valid;

    logic [cma_pkg::CFG_W-1:0]     m_last;
    logic                          last_col;
    logic                          last_pair;
    logic [ADDR_W-1:0]             addr;
    logic signed [PROD_W-1:0]      prod;
    logic [SW-1:0]                 base;
    logic [SW-1:0]                 wr_data;
    logic [SW-1:0]                 clamped;
    logic                          out_busy;
    logic                          out_load;

    // pair position
    assign m_last    = i_chan - 1'b1;
    assign last_col  = (r_col == m_last[CW-1:0]);
    assign last_pair = last_col && (r_row == m_last[CW-1:0]);
    assign addr      = ADDR_W'(int'(r_row) * MAX_CHANNELS + int'(r_col));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rc_clr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_ctrl.rc_adv) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_func <= i_func;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_x[i] <= $signed(SAMPLE_BITS'(i_samples[cma_pkg::FIELD_W*i +: cma_pkg::FIELD_W]));
            end
        end
    end

    // multiply stage, then read-add-write of the accumulator
    assign prod    = r_x[r_row[CI_W-1:0]] * r_x[r_col[CI_W-1:0]];
    assign base    = r_rd_vld ? r_rd_data : '0;
    assign wr_data = base + {{(SW-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac || i_ctrl.mem_rd) begin
            r_rd_data <= mem[addr];
            r_rd_vld  <= r_vld[addr];
        end
        r_wr_addr <= addr;
        r_prod    <= prod;
        if (r_wr_en) begin
            mem[r_wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
            r_vld   <= '0;
            r_count <= '0;
        end else begin
            r_wr_en <= i_ctrl.mac;
            if (i_ctrl.acc_clr) begin
                r_vld   <= '0;
                r_count <= '0;
            end else begin
                if (r_wr_en) begin
                    r_vld[r_wr_addr] <= 1'b1;
                end
                if (i_ctrl.cnt_inc && r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // divide setup: magnitude of the sum over count minus one
    assign o_div_start = i_ctrl.div_go;
    assign o_dividend  = base[SW-1] ? (~base + 1'b1) : base;
    assign o_divisor   = (r_count > 1) ? r_count - 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_go) begin
            r_neg <= base[SW-1];
        end
    end

    // output register
    assign clamped  = (i_quotient > LIMIT) ? LIMIT : i_quotient;
    assign out_busy = r_out_valid && !i_out_ready;
    assign out_load = i_ctrl.out_load && !out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_row   <= r_row;
            o_col   <= r_col;
            o_value <= r_neg ? (~clamped[VW-1:0] + 1'b1) : clamped[VW-1:0];
            o_last  <= last_pair;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.accept   = i_accept;
    assign o_stat.finish   = r_func;
    assign o_stat.not_last = !last_pair;
    assign o_stat.div_busy = i_div_busy;
    assign o_stat.out_busy = out_busy;

endmodule

`default_nettype wire

/* rtl/core/covariance_matrix_accumulator.sv */
// sample covariance accumulator
// input stream: one transfer per time point; tuser = 0 accumulates the sample
//   vector in tdata (ch0 in the low 16 bits), tuser = 1 finishes the run
// accumulate: every pair of the first M channels is multiplied and added into
//   a 64-bit sum; one shared multiplier does one pair per cycle, so a sample
//   transfer occupies the block until all M*M pairs are done
// finish: the M*M entries leave row-major on the output stream, tlast on the
//   last one; each sum is divided by count - 1 on a bit-serial divider
//   (when at most one sample was seen, the raw sum goes out undivided);
//   values clamp to [-2^31, 2^31]
// after the last entry all sums and the sample count are dropped at once
// config: a 4-bit channel count M (0 acts as 1, above MAX_CHANNELS is clamped),
//   to be written by the user only while idle, which the block leaves unenforced; always ready
// reset: sums and count empty, M = 8, both streams idle
// output stall: the entry waits in the output register and the sequencer
//   holds on its output step; once the last entry is loaded the next sample
//   transfer is taken while that entry still waits
`default_nettype none

module covariance_matrix_accumulator #(
    parameter int MAX_CHANNELS = cma_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // sample stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [cma_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // ch0..ch7, 16 bits each
    input  wire                               i_s_axis_tuser,  // func
    // covariance stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [cma_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // row, col, value, zero pad
    output logic                              o_m_axis_tlast,  // last entry of the matrix
    // channel count register
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [cma_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam logic [cma_pkg::CFG_W-1:0] CH_MAX = cma_pkg::CFG_W'(MAX_CHANNELS);

    logic [cma_pkg::CFG_W-1:0]   r_chan_cfg;
    logic [cma_pkg::CFG_W-1:0]   chan;
    cma_pkg::t_ctrl              ctrl;
    cma_pkg::t_stat              stat;
    logic                        accept;
    logic                        div_start;
    logic                        div_busy;
    logic [cma_pkg::SUM_W-1:0]   dividend;
    logic [cma_pkg::COUNT_W-1:0] divisor;
    logic [cma_pkg::SUM_W-1:0]   quotient;
    logic [cma_pkg::CH_W-1:0]    row;
    logic [cma_pkg::CH_W-1:0]    col;
    logic [cma_pkg::VALUE_W-1:0] value;

    // channel count register, clamped into 1..MAX_CHANNELS
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cfg <= cma_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_chan_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_chan_cfg == '0) begin
            chan = cma_pkg::CFG_W'(1);
        end else if (r_chan_cfg > CH_MAX) begin
            chan = CH_MAX;
        end else begin
            chan = r_chan_cfg;
        end
    end

    // input transfer only in the wait step of the program
    assign o_s_axis_tready = ctrl.ready;
    assign accept          = ctrl.ready && i_s_axis_tvalid;

    cma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    cma_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_accept    (accept),
        .i_samples   (i_s_axis_tdata),
        .i_func      (i_s_axis_tuser),
        .i_chan      (chan),
        .i_out_ready (i_m_axis_tready),
        .i_div_busy  (div_busy),
        .i_quotient  (quotient),
        .o_div_start (div_start),
        .o_dividend  (dividend),
        .o_divisor   (divisor),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_row       (row),
        .o_col       (col),
        .o_value     (value),
        .o_last      (o_m_axis_tlast)
    );

    cma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // pack row, col and value from bit 0 up
    assign o_m_axis_tdata = cma_pkg::OUT_TDATA_W'({value, col, row});

endmodule

`default_nettype wire

/* bench/covariance_matrix_accumulator_test.sv */
`timescale 1ns / 1ps

typedef enum bit {
    FUNC_ACCUM  = 1'b0,     // add the sample vector into the pair sums
    FUNC_FINISH = 1'b1      // emit the matrix and start over
} t_sample_func;

// one emitted covariance entry
typedef struct packed {
    bit [cma_pkg::CH_W-1:0]    row;
    bit [cma_pkg::CH_W-1:0]    col;
    bit [cma_pkg::VALUE_W-1:0] value;
    bit                        last;
} t_cov_entry;

// shadow of the pair sums and sample count, plus the queue of entries still owed
class t_cov_scoreboard;
    localparam int MAXCH = cma_pkg::MAX_CHANNELS_DEF;

    longint       pair_sums[MAXCH*MAXCH];
    bit [31:0]    n_samples;
    bit [3:0]     chan_reg;
    t_cov_entry   owed_q[$];
    int           errors;

    function new();
        foreach (pair_sums[k]) pair_sums[k] = 0;
        n_samples = '0;
        chan_reg  = cma_pkg::CFG_RESET;
        errors    = 0;
    endfunction

    function void set_channels(bit [3:0] m);
        chan_reg = m;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // zero acts as one, anything above the store size is clamped
    function int active_m();
        if (chan_reg == 0) return 1;
        if (chan_reg > MAXCH) return MAXCH;
        return chan_reg;
    endfunction

    // divide toward zero (divisor 0 means raw), clamp to [-2^31, 2^31]
    function bit [cma_pkg::VALUE_W-1:0] scale_entry(longint sum, longint unsigned divisor);
        bit              neg;
        longint unsigned mag;
        neg = sum[63];
        mag = neg ? -sum : sum;
        if (divisor != 0) mag = mag / divisor;
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        if (neg) mag = -mag;
        return mag[cma_pkg::VALUE_W-1:0];
    endfunction

    function void note_sample(t_sample_func func, bit [cma_pkg::IN_TDATA_W-1:0] data);
        longint          x[MAXCH];
        longint unsigned divisor;
        t_cov_entry      e;
        int              m;
        m = active_m();
        if (func == FUNC_ACCUM) begin
            for (int r = 0; r < m; r++)
                x[r] = longint'($signed(data[r*cma_pkg::FIELD_W +: cma_pkg::FIELD_W]));
            for (int r = 0; r < m; r++)
                for (int c = 0; c < m; c++)
                    pair_sums[r*MAXCH+c] += x[r] * x[c];
            if (n_samples != 32'hFFFF_FFFF) n_samples++;
        end else begin
            divisor = (n_samples > 1) ? longint'(n_samples) - 1 : 0;
            for (int r = 0; r < m; r++)
                for (int c = 0; c < m; c++) begin
                    e.row   = r[cma_pkg::CH_W-1:0];
                    e.col   = c[cma_pkg::CH_W-1:0];
                    e.value = scale_entry(pair_sums[r*MAXCH+c], divisor);
                    e.last  = (r == m - 1) && (c == m - 1);
                    owed_q.push_back(e);
                end
            // every sum is dropped, not only the ones emitted
            foreach (pair_sums[k]) pair_sums[k] = 0;
            n_samples = '0;
        end
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(bit [cma_pkg::OUT_TDATA_W-1:0] data, bit last);
        t_cov_entry e;
        bit [cma_pkg::CH_W-1:0]    got_row;
        bit [cma_pkg::CH_W-1:0]    got_col;
        bit [cma_pkg::VALUE_W-1:0] got_val;
        got_row = data[0 +: cma_pkg::CH_W];
        got_col = data[cma_pkg::CH_W +: cma_pkg::CH_W];
        got_val = data[2*cma_pkg::CH_W +: cma_pkg::VALUE_W];
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected entry row %0d col %0d", got_row, got_col));
        end else begin
            e = owed_q.pop_front();
            if (got_row != e.row)
                report_mismatch($sformatf("row %0d, want %0d", got_row, e.row));
            if (got_col != e.col)
                report_mismatch($sformatf("col %0d, want %0d", got_col, e.col));
            if (got_val != e.value)
                report_mismatch($sformatf("(%0d,%0d) value %h, want %h",
                                          e.row, e.col, got_val, e.value));
            if (last != e.last)
                report_mismatch($sformatf("(%0d,%0d) tlast %0d, want %0d",
                                          e.row, e.col, last, e.last));
        end
    endtask
endclass

module covariance_matrix_accumulator_test;

    localparam int SETTLE_CYCLES   = 80;    // outlasts the time a sample transfer keeps the block busy
    localparam int ITEMS_PER_PHASE = 32;
    localparam int HOLD_CYCLES     = 600;
    localparam int N_PHASES        = 12;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            smp_tvalid;
    logic                            smp_tready;
    logic [cma_pkg::IN_TDATA_W-1:0]  smp_tdata;      // ch0..ch7, 16 bits each
    logic                            smp_tuser;      // func
    logic                            cov_tvalid;
    logic                            cov_tready;
    logic [cma_pkg::OUT_TDATA_W-1:0] cov_tdata;      // row, col, value, zero pad
    logic                            cov_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cma_pkg::CFG_W-1:0]       cfg_data;

    int  idle_pct;          // sender gap odds, per cycle
    int  stall_pct;         // receiver stall odds, per cycle
    int  hold_req;          // one long receiver hold-off, in cycles
    bit  hold_taken;
    int  hold_left;

    t_cov_scoreboard sb;

    // channel count per random phase: both ends, zero and the clamped range included
    int phase_chans[N_PHASES] = '{0, 15, 3, 8, 1, 9, 5, 8, 2, 6, 4, 7};

    covariance_matrix_accumulator u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (smp_tvalid),
        .o_s_axis_tready (smp_tready),
        .i_s_axis_tdata  (smp_tdata),
        .i_s_axis_tuser  (smp_tuser),
        .o_m_axis_tvalid (cov_tvalid),
        .i_m_axis_tready (cov_tready),
        .o_m_axis_tdata  (cov_tdata),
        .o_m_axis_tlast  (cov_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk) begin
        if (!hold_taken && hold_req != 0) begin
            hold_taken = 1'b1;
            hold_left  = hold_req;
        end
        if (hold_left > 0) begin
            cov_tready <= 1'b0;
            hold_left  = hold_left - 1;
        end else begin
            cov_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // every output transfer goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && cov_tvalid && cov_tready)
            sb.check_result(cov_tdata, cov_tlast);
    end

    // lane mix: extremes, zero, minus one, small values and full-range noise
    function automatic logic [cma_pkg::IN_TDATA_W-1:0] make_vector();
        logic [cma_pkg::IN_TDATA_W-1:0] v;
        for (int k = 0; k < cma_pkg::LANES; k++) begin
            case ($urandom_range(7))
                0:       v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = 16'h8000;
                1:       v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = 16'h7fff;
                2:       v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = 16'h0000;
                3:       v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = 16'hffff;
                4:       v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] =
                             16'($signed($urandom_range(512)) - 256);
                default: v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    // even lanes get a, odd lanes get b
    function automatic logic [cma_pkg::IN_TDATA_W-1:0] fill_lanes(logic [15:0] a,
                                                                  logic [15:0] b);
        logic [cma_pkg::IN_TDATA_W-1:0] v;
        for (int k = 0; k < cma_pkg::LANES; k++)
            v[k*cma_pkg::FIELD_W +: cma_pkg::FIELD_W] = k[0] ? b : a;
        return v;
    endfunction

    function automatic logic [cma_pkg::IN_TDATA_W-1:0] noise_bits();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // offer one transfer, with random gaps ahead of it, and wait for the handshake
    task automatic send_item(input t_sample_func func,
                             input logic [cma_pkg::IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            smp_tvalid <= 1'b0;
            @(posedge clk);
        end
        smp_tvalid <= 1'b1;
        smp_tuser  <= func;
        smp_tdata  <= data;
        do @(posedge clk); while (!smp_tready);
        sb.note_sample(func, data);
    endtask

    task automatic send_run(input int n_acc);
        repeat (n_acc) send_item(FUNC_ACCUM, make_vector());
        send_item(FUNC_FINISH, noise_bits());
    endtask

    // stop offering, wait for every owed entry, then let the sequencer go quiet
    task automatic settle();
        smp_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channels(input logic [cma_pkg::CFG_W-1:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_channels(m);
    endtask

    initial begin
        int sent;
        int pick;
        int n_acc;

        sb         = new;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 0;
        hold_taken = 1'b0;
        hold_left  = 0;
        rst_n      = 1'b0;
        smp_tvalid = 1'b0;
        smp_tdata  = '0;
        smp_tuser  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cov_tready = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, M = 8 out of reset
        // finish with nothing seen: raw zero sums
        send_item(FUNC_FINISH, {cma_pkg::IN_TDATA_W{1'b1}});
        // one sample: raw sums of 2^30
        send_item(FUNC_ACCUM, fill_lanes(16'h8000, 16'h8000));
        send_item(FUNC_FINISH, '0);
        // two full-scale negative samples: quotient hits exactly 2^31
        send_item(FUNC_ACCUM, fill_lanes(16'h8000, 16'h8000));
        send_item(FUNC_ACCUM, fill_lanes(16'h8000, 16'h8000));
        send_item(FUNC_FINISH, noise_bits());
        // mixed signs, divisor 3: negative quotients truncate toward zero
        send_item(FUNC_ACCUM, fill_lanes(16'h7fff, 16'h7fff));
        send_item(FUNC_ACCUM, fill_lanes(16'h7fff, 16'h8000));
        send_item(FUNC_ACCUM, fill_lanes(16'hffff, 16'hffff));
        send_item(FUNC_ACCUM, fill_lanes(16'h0000, 16'h0001));
        send_item(FUNC_FINISH, noise_bits());
        send_run(3);
        settle();

        // channel count changed between samples: only touched pairs move
        write_channels(cma_pkg::CFG_W'(2));
        send_item(FUNC_ACCUM, make_vector());
        send_item(FUNC_ACCUM, noise_bits());
        settle();
        write_channels(cma_pkg::CFG_W'(8));
        send_item(FUNC_ACCUM, make_vector());
        settle();
        // finish at M = 1 still has to drop all 64 sums
        write_channels(cma_pkg::CFG_W'(1));
        send_item(FUNC_FINISH, noise_bits());
        settle();
        write_channels(cma_pkg::CFG_W'(8));
        send_item(FUNC_FINISH, noise_bits());
        settle();

        // random part: runs of samples closed by a finish
        for (int p = 0; p < N_PHASES; p++) begin
            write_channels(cma_pkg::CFG_W'(phase_chans[p]));
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 61;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 61;
                end
                default: begin
                    idle_pct = 24;
                    stall_pct <= 24;
                end
            endcase
            // receiver goes away for a while so the block backs up into its input
            if (p == 2) hold_req <= HOLD_CYCLES;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(9);
                if (pick == 0)      n_acc = 0;
                else if (pick == 1) n_acc = 1;
                else                n_acc = $urandom_range(6, 2);
                send_run(n_acc);
                sent += n_acc + 1;
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
